@@ hdl/rx_fifo_line_end_normalizer_assert.svh @@
// assertion macros for the line end normalizer checker
// depends on nothing; included by the checker file only
`ifndef RX_FIFO_LINE_END_NORMALIZER_ASSERT_SVH
`define RX_FIFO_LINE_END_NORMALIZER_ASSERT_SVH

// same-cycle implication, held off during reset
`define RXN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define RXN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rxn_pkg.sv @@
// shared types, constants and pointer helpers for the line end normalizer
// no dependencies
`default_nettype none

package rxn_pkg;

    // receive fifo geometry
    localparam int FIFO_DEPTH = 256;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // configuration
    localparam logic [15:0] CR_WAIT_RESET = 16'd2000;

    // character codes
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CTRL_A = 8'h01;

    // action codes of an input word
    localparam logic [1:0] ACT_RX   = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] fifo_level;
    } result_t;

    // one write port of the fifo store
    typedef struct packed {
        logic       en;
        ptr_t       addr;
        logic [7:0] data;
    } mem_wr_t;

    // ring pointer advance with wrap at the last slot
    function automatic ptr_t ptr_next(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(FIFO_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    // bytes held between read and write pointers, saturated at 255
    function automatic logic [7:0] level_of(input ptr_t wp, input ptr_t rp);
        logic [PTR_W:0] diff;
        logic [7:0]     lv;
        if (wp >= rp)
            diff = {1'b0, wp} - {1'b0, rp};
        else
            diff = {1'b0, wp} + (PTR_W+1)'(FIFO_DEPTH) - {1'b0, rp};
        if (32'(diff) > 32'd255)
            lv = 8'hFF;
        else
            lv = 8'(diff);
        return lv;
    endfunction

endpackage

`default_nettype wire

@@ hdl/rxn_fifo_mem.sv @@
// receive fifo store: one write port, two registered read ports with write bypass
// depends on rxn_pkg
`default_nettype none

module rxn_fifo_mem (
    input  wire logic            clk,
    input  wire rxn_pkg::mem_wr_t wr,
    input  wire rxn_pkg::ptr_t   rd_addr0,
    input  wire rxn_pkg::ptr_t   rd_addr1,
    output logic [7:0]           rd_data0,
    output logic [7:0]           rd_data1
);

    logic [7:0] mem [rxn_pkg::FIFO_DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
    end

    // read ports, a same-edge write to the read address is forwarded
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == rd_addr0))
            rd_data0 <= wr.data;
        else
            rd_data0 <= mem[rd_addr0];
        if (wr.en && (wr.addr == rd_addr1))
            rd_data1 <= wr.data;
        else
            rd_data1 <= mem[rd_addr1];
    end

endmodule

`default_nettype wire

@@ hdl/rxn_core.sv @@
// normalizer state, fifo pointers and the one-word step logic
// depends on rxn_pkg and rxn_fifo_mem
`default_nettype none

module rxn_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire rxn_pkg::item_t   item,
    input  wire logic [15:0]      cr_wait,
    output logic                  res_valid,
    output rxn_pkg::result_t      res
);

    rxn_pkg::ptr_t    wp_reg, wp_next;
    rxn_pkg::ptr_t    rp_reg, rp_next;
    logic [7:0]       held_byte_reg, held_byte_next;
    logic             held_valid_reg, held_valid_next;
    logic             read_waiting_reg, read_waiting_next;
    logic             after_cr_reg, after_cr_next;
    logic [15:0]      ticks_reg, ticks_next;

    rxn_pkg::mem_wr_t mem_wr;
    logic [7:0]       rd0, rd1;
    rxn_pkg::ptr_t    rp1, rp2;
    logic             push;
    logic             avail0, avail1;
    logic [7:0]       head0, head1;
    logic             follow;
    logic [7:0]       follow_byte;
    logic             got;
    logic [7:0]       ch;

    // fifo store, read data always tracks the two slots at the head
    rxn_fifo_mem u_mem (
        .clk      (clk),
        .wr       (mem_wr),
        .rd_addr0 (rp_next),
        .rd_addr1 (rxn_pkg::ptr_next(rp_next)),
        .rd_data0 (rd0),
        .rd_data1 (rd1)
    );

    // head slots, the word being pushed now may already be at the head
    always_comb
    begin
        rp1    = rxn_pkg::ptr_next(rp_reg);
        rp2    = rxn_pkg::ptr_next(rp1);
        push   = advance && (item.action == rxn_pkg::ACT_RX)
                 && (rxn_pkg::ptr_next(wp_reg) != rp_reg);
        wp_next = push ? rxn_pkg::ptr_next(wp_reg) : wp_reg;
        avail0 = (rp_reg != wp_next);
        avail1 = (rp1 != wp_next);
        head0  = (push && (rp_reg == wp_reg)) ? item.rx_byte : rd0;
        head1  = (push && (rp1 == wp_reg)) ? item.rx_byte : rd1;
        mem_wr.en   = push;
        mem_wr.addr = wp_reg;
        mem_wr.data = item.rx_byte;
    end

    // step logic: tick timeout, then serving a pending reader
    always_comb
    begin
        rp_next           = rp_reg;
        held_byte_next    = held_byte_reg;
        held_valid_next   = held_valid_reg;
        read_waiting_next = read_waiting_reg;
        after_cr_next     = after_cr_reg;
        ticks_next        = ticks_reg;
        follow            = 1'b0;
        follow_byte       = head0;
        got               = 1'b0;
        ch                = rxn_pkg::CH_CR;

        if (advance)
        begin
            if (item.action == rxn_pkg::ACT_READ)
                read_waiting_next = 1'b1;

            // tick counts down a running cr wait
            if ((item.action == rxn_pkg::ACT_TICK) && read_waiting_reg && after_cr_reg)
            begin
                if (ticks_reg != 16'd0)
                    ticks_next = ticks_reg - 16'd1;
                if (ticks_next == 16'd0)
                begin
                    after_cr_next = 1'b0;
                    got           = 1'b1;
                    ch            = rxn_pkg::CH_CR;
                end
            end

            if (!got && read_waiting_next)
            begin
                if (after_cr_next)
                begin
                    if (avail0)
                    begin
                        rp_next     = rp1;
                        follow      = 1'b1;
                        follow_byte = head0;
                    end
                end
                else if (held_valid_reg)
                begin
                    held_valid_next = 1'b0;
                    got             = 1'b1;
                    ch              = held_byte_reg;
                end
                else if (avail0)
                begin
                    rp_next = rp1;
                    if (head0 == rxn_pkg::CH_LF)
                    begin
                        got = 1'b1;
                        ch  = rxn_pkg::CH_CR;
                    end
                    else if (head0 != rxn_pkg::CH_CR)
                    begin
                        got = 1'b1;
                        ch  = head0;
                    end
                    else if (cr_wait == 16'd0)
                    begin
                        got = 1'b1;
                        ch  = rxn_pkg::CH_CR;
                    end
                    else
                    begin
                        // cr starts a wait, the next byte may settle it at once
                        after_cr_next = 1'b1;
                        ticks_next    = cr_wait;
                        if (avail1)
                        begin
                            rp_next     = rp2;
                            follow      = 1'b1;
                            follow_byte = head1;
                        end
                    end
                end
            end

            // byte following a cr settles the wait
            if (follow)
            begin
                after_cr_next = 1'b0;
                ticks_next    = 16'd0;
                got           = 1'b1;
                if (follow_byte == rxn_pkg::CH_LF)
                    ch = rxn_pkg::CH_CR;
                else if (follow_byte == rxn_pkg::CH_CTRL_A)
                    ch = rxn_pkg::CH_CTRL_A;
                else
                begin
                    held_byte_next  = follow_byte;
                    held_valid_next = 1'b1;
                    ch              = rxn_pkg::CH_CR;
                end
            end

            if (got)
                read_waiting_next = 1'b0;
        end

        res_valid      = got;
        res.data       = ch;
        res.fifo_level = rxn_pkg::level_of(wp_next, rp_next);
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg           <= '0;
            rp_reg           <= '0;
            held_byte_reg    <= '0;
            held_valid_reg   <= 1'b0;
            read_waiting_reg <= 1'b0;
            after_cr_reg     <= 1'b0;
            ticks_reg        <= '0;
        end
        else
        begin
            wp_reg           <= wp_next;
            rp_reg           <= rp_next;
            held_byte_reg    <= held_byte_next;
            held_valid_reg   <= held_valid_next;
            read_waiting_reg <= read_waiting_next;
            after_cr_reg     <= after_cr_next;
            ticks_reg        <= ticks_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rx_fifo_line_end_normalizer.sv @@
// Receive fifo with line end normalization for a serial console reader.
//
// Channels:
//   item / item_valid / item_stall      one word per event: a received byte,
//                                       a read request or a time tick
//   result / result_valid / result_stall one normalized character for the
//                                       pending reader, with the fifo level
//   cfg_data / cfg_valid / cfg_ready    cr_wait_ticks register, always ready
// Path: an accepted word lands in the input register; the step logic between
// the registers forms its result, if any, and the result register shows it.
// Throughput: one word per cycle while the result is not stalled; the step
// logic handles a push and up to two pops of the 256 byte store each cycle.
// Reset: fifo empty, no reader pending, cr_wait_ticks = 2000. The store
// itself is not cleared and no slot is read before it is written.
// When the receiver stalls, the result register holds; the input register
// still takes one more word, then item_stall rises until the result leaves.
// depends on rxn_pkg and rxn_core
`default_nettype none

module rx_fifo_line_end_normalizer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rxn_pkg::item_t   item,
    input  wire logic             item_valid,
    output logic                  item_stall,
    output rxn_pkg::result_t      result,
    output logic                  result_valid,
    input  wire logic             result_stall,
    input  wire logic [15:0]      cfg_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready
);

    logic             in_valid_reg;
    rxn_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    rxn_pkg::result_t out_item_reg;
    logic [15:0]      cr_wait_reg;
    logic             advance;
    logic             res_valid;
    rxn_pkg::result_t res;

    // the held word moves on when the result register is free or draining
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign cfg_ready  = 1'b1;

    rxn_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (in_item_reg),
        .cr_wait   (cr_wait_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_valid && !item_stall)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_item_reg <= item;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_item_reg <= res;
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cr_wait_reg <= rxn_pkg::CR_WAIT_RESET;
        else if (cfg_valid && cfg_ready)
            cr_wait_reg <= cfg_data;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

`default_nettype wire

@@ hdl/rx_fifo_line_end_normalizer_chk.sv @@
// port level checks for the line end normalizer, bound to the top level
// depends on rxn_pkg and rx_fifo_line_end_normalizer_assert.svh
`default_nettype none

`include "rx_fifo_line_end_normalizer_assert.svh"

module rx_fifo_line_end_normalizer_chk (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire rxn_pkg::item_t   item,
    input wire logic             item_valid,
    input wire logic             item_stall,
    input wire rxn_pkg::result_t result,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire logic             cfg_valid,
    input wire logic             cfg_ready
);

    // a stalled result word stays put
    `RXN_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

    // a stalled input word stays put
    `RXN_ASSERT_NEXT(a_item_hold, clk, rst_n, item_valid && item_stall, item_valid && $stable(item), "stalled input changed")

    // line feeds never reach the reader
    `RXN_ASSERT_NOW(a_no_lf_out, clk, rst_n, result_valid, result.data != rxn_pkg::CH_LF, "line feed delivered")

    // input backs up only behind a stalled result
    `RXN_ASSERT_NOW(a_stall_cause, clk, rst_n, item_stall, result_valid && result_stall, "input stalled with output free")

    // register writes are never refused
    `RXN_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "config write refused")

endmodule

bind rx_fifo_line_end_normalizer rx_fifo_line_end_normalizer_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire
